// ----- rtl/llr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package llr_pkg;

  localparam int PIX_W           = 8;
  localparam int CFG_LEN_W       = 13;
  localparam int STEP_W          = 24;
  localparam int PADDR_W         = 4;
  localparam int PDATA_W         = 32;

  localparam int MAX_LINE_DEF    = 4096;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_UPSCALE_DEF = 16;

  localparam logic [CFG_LEN_W-1:0] SRC_LEN_RST = CFG_LEN_W'(512);
  localparam logic [CFG_LEN_W-1:0] DST_LEN_RST = CFG_LEN_W'(512);

  typedef enum logic [1:0] {
    REG_SRC_LEN = 2'd0,
    REG_DST_LEN = 2'd1,
    REG_STEP    = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_now;
    logic more;
    logic slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/linear_line_resampler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Linear resampler for one line of 8-bit pixels. An accepted source pixel
// is first registered, then each destination pixel it causes (at most MAX_UPSCALE)
// is emitted in turn, paced by the single interpolation multiplier in the
// datapath that forms one result per cycle while the output slot is free;
// a source pixel that causes no result is finished without one. Results
// wait in an output register, so the next source pixel can be taken while
// the last result is still stalled. Registers: src_len at 0x0, dst_len at
// 0x4, step_q16 (Q8.16 source step per destination pixel) at 0x8; write
// them only between lines or while the block is idle.
module linear_line_resampler_top #(
  parameter int MAX_LINE    = llr_pkg::MAX_LINE_DEF,
  parameter int FRAC_BITS   = llr_pkg::FRAC_BITS_DEF,
  parameter int MAX_UPSCALE = llr_pkg::MAX_UPSCALE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [llr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [llr_pkg::PDATA_W-1:0] pwdata,
  output logic      [llr_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [llr_pkg::PIX_W-1:0]   src_pixel,
  input  wire logic                        last_in_line,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [llr_pkg::PIX_W-1:0]   dst_pixel,
  output logic                             last_of_run,
  output logic                             line_done
);
  import llr_pkg::*;

  logic [CFG_LEN_W-1:0] src_len;
  logic [CFG_LEN_W-1:0] dst_len;
  logic [STEP_W-1:0]    step_q16;
  dp_cmd_t              cmd;
  dp_status_t           status;

  llr_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .src_len  (src_len),
    .dst_len  (dst_len),
    .step_q16 (step_q16)
  );

  llr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  llr_datapath #(
    .MAX_LINE    (MAX_LINE),
    .FRAC_BITS   (FRAC_BITS),
    .MAX_UPSCALE (MAX_UPSCALE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .src_len      (src_len),
    .dst_len      (dst_len),
    .step_q16     (step_q16),
    .src_pixel    (src_pixel),
    .last_in_line (last_in_line),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dst_pixel    (dst_pixel),
    .last_of_run  (last_of_run),
    .line_done    (line_done)
  );

endmodule

`default_nettype wire

// ----- rtl/llr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llr_cfg #(
  parameter int FRAC_BITS = llr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [llr_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [llr_pkg::PDATA_W-1:0]    pwdata,
  output logic      [llr_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready,
  output logic      [llr_pkg::CFG_LEN_W-1:0]  src_len,
  output logic      [llr_pkg::CFG_LEN_W-1:0]  dst_len,
  output logic      [llr_pkg::STEP_W-1:0]     step_q16
);
  import llr_pkg::*;

  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(1 << FRAC_BITS);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_len  <= SRC_LEN_RST;
      dst_len  <= DST_LEN_RST;
      step_q16 <= STEP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SRC_LEN: src_len  <= pwdata[CFG_LEN_W-1:0];
        REG_DST_LEN: dst_len  <= pwdata[CFG_LEN_W-1:0];
        REG_STEP:    step_q16 <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_LEN: prdata = PDATA_W'(src_len);
      REG_DST_LEN: prdata = PDATA_W'(dst_len);
      REG_STEP:    prdata = PDATA_W'(step_q16);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/llr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire llr_pkg::dp_status_t status,
  output llr_pkg::dp_cmd_t         cmd
);
  import llr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status.emit_now) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (!status.more) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/llr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llr_datapath #(
  parameter int MAX_LINE    = llr_pkg::MAX_LINE_DEF,
  parameter int FRAC_BITS   = llr_pkg::FRAC_BITS_DEF,
  parameter int MAX_UPSCALE = llr_pkg::MAX_UPSCALE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [llr_pkg::CFG_LEN_W-1:0] src_len,
  input  wire logic [llr_pkg::CFG_LEN_W-1:0] dst_len,
  input  wire logic [llr_pkg::STEP_W-1:0]    step_q16,
  input  wire logic [llr_pkg::PIX_W-1:0]     src_pixel,
  input  wire logic                          last_in_line,
  input  wire llr_pkg::dp_cmd_t              cmd,
  output llr_pkg::dp_status_t                status,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [llr_pkg::PIX_W-1:0]     dst_pixel,
  output logic                               last_of_run,
  output logic                               line_done
);
  import llr_pkg::*;

  localparam int IDX_W = $clog2(MAX_LINE);
  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam int POS_W = IDX_W + FRAC_BITS;
  localparam int SUM_W = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
  localparam int CNT_W = $clog2(MAX_UPSCALE + 1);
  localparam int V_W   = PIX_W + FRAC_BITS + 2;
  localparam logic [V_W-1:0] HALF = V_W'(1) << (FRAC_BITS - 1);

  // line state
  logic [PIX_W-1:0] prev_pixel;
  logic [IDX_W-1:0] src_index;
  logic [LEN_W-1:0] dst_index;
  logic [POS_W-1:0] position_acc;

  // per-request state
  logic [PIX_W-1:0] cur_pixel;
  logic             last_flag;
  logic [CNT_W-1:0] run_cnt;
  logic             fill;

  logic [CMP_W-1:0] src_len_w;
  logic [CMP_W-1:0] dst_len_w;
  logic [LEN_W-1:0] sl;
  logic [LEN_W-1:0] dl;
  logic [LEN_W-1:0] sl_m1;
  logic [POS_W-1:0] limit;
  logic [LEN_W-1:0] k_p1;
  logic [IDX_W-1:0] km1;
  logic [IDX_W-1:0] acc_int;
  logic [IDX_W-1:0] adv_int;
  logic [SUM_W-1:0] acc_sum;
  logic [POS_W-1:0] acc_adv;
  logic [CNT_W-1:0] cnt_p1;
  logic [LEN_W-1:0] dst_p1;
  logic             last_at_accept;
  logic             interp_ok;
  logic             interp_after;

  logic signed [PIX_W:0]   diff;
  logic signed [V_W-1:0]   prod;
  logic signed [V_W-1:0]   base;
  logic signed [V_W-1:0]   v;
  logic        [PIX_W-1:0] interp_px;
  logic        [PIX_W-1:0] res_px;

  // length clamp to 2..MAX_LINE
  assign src_len_w = CMP_W'(src_len);
  assign dst_len_w = CMP_W'(dst_len);
  assign sl = (src_len_w < CMP_W'(2)) ? LEN_W'(2) :
              (src_len_w > CMP_W'(MAX_LINE)) ? LEN_W'(MAX_LINE) : LEN_W'(src_len_w);
  assign dl = (dst_len_w < CMP_W'(2)) ? LEN_W'(2) :
              (dst_len_w > CMP_W'(MAX_LINE)) ? LEN_W'(MAX_LINE) : LEN_W'(dst_len_w);
  assign sl_m1 = sl - LEN_W'(1);
  assign limit = {sl_m1[IDX_W-1:0], {FRAC_BITS{1'b0}}};

  assign k_p1           = LEN_W'(src_index) + LEN_W'(1);
  assign km1            = src_index - IDX_W'(1);
  assign last_at_accept = last_in_line || (k_p1 >= sl);

  assign acc_int = position_acc[POS_W-1:FRAC_BITS];
  assign acc_sum = SUM_W'(position_acc) + SUM_W'(step_q16);
  assign acc_adv = (acc_sum > SUM_W'(limit)) ? limit : acc_sum[POS_W-1:0];
  assign adv_int = acc_adv[POS_W-1:FRAC_BITS];

  assign cnt_p1 = run_cnt + CNT_W'(1);
  assign dst_p1 = dst_index + LEN_W'(1);

  assign interp_ok    = !fill && (src_index != '0) && (acc_int <= km1);
  assign interp_after = interp_ok && (adv_int <= km1);

  assign status.emit_now  = (run_cnt < CNT_W'(MAX_UPSCALE)) && (dst_index < dl) &&
                            (last_flag || interp_ok);
  assign status.more      = (cnt_p1 < CNT_W'(MAX_UPSCALE)) && (dst_p1 < dl) &&
                            (last_flag || interp_after);
  assign status.slot_free = !out_valid || !out_stall;

  // prev + (cur - prev) * frac, rounded half up
  assign diff = $signed({1'b0, cur_pixel}) - $signed({1'b0, prev_pixel});
  assign prod = diff * $signed({1'b0, position_acc[FRAC_BITS-1:0]});
  assign base = $signed({2'b00, prev_pixel, {FRAC_BITS{1'b0}}});
  assign v    = base + prod + $signed(HALF);

  always_comb begin
    if (v[V_W-1]) begin
      interp_px = '0;
    end else if (v[V_W-2:FRAC_BITS+PIX_W] != '0) begin
      interp_px = '1;
    end else begin
      interp_px = v[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  end

  assign res_px = interp_ok ? interp_px : cur_pixel;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_pixel <= src_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pixel   <= '0;
      src_index    <= '0;
      dst_index    <= '0;
      position_acc <= '0;
      last_flag    <= 1'b0;
      run_cnt      <= '0;
      fill         <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_flag <= last_at_accept;
        run_cnt   <= '0;
        fill      <= 1'b0;
      end
      if (cmd.emit) begin
        run_cnt <= cnt_p1;
        fill    <= !interp_ok;
      end
      if (cmd.finish && last_flag) begin
        dst_index    <= '0;
        position_acc <= '0;
      end else if (cmd.emit) begin
        dst_index    <= dst_p1;
        position_acc <= acc_adv;
      end
      if (cmd.finish) begin
        prev_pixel <= cur_pixel;
        src_index  <= last_flag ? '0 : k_p1[IDX_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dst_pixel   <= res_px;
      last_of_run <= !status.more;
      line_done   <= last_flag && !status.more;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/llr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llr_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [llr_pkg::PIX_W-1:0] dst_pixel,
  input wire logic                      last_of_run,
  input wire logic                      line_done
);
  import llr_pkg::*;

  // one request in flight at a time
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still running");

  a_line_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_done) |-> last_of_run)
    else $error("line_done without last_of_run");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      ($stable(dst_pixel) && $stable(last_of_run) && $stable(line_done)))
    else $error("stalled result changed");

endmodule

bind linear_line_resampler_top llr_checker u_llr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .dst_pixel    (dst_pixel),
  .last_of_run  (last_of_run),
  .line_done    (line_done)
);

`default_nettype wire

// ----- bench/linear_line_resampler_top_tb.sv -----
`timescale 1ns / 1ps

module linear_line_resampler_top_tb;
  import llr_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int MAX_UP       = MAX_UPSCALE_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             run_end;
    logic             line_end;
  } dst_beat_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [PIX_W-1:0]   src_pixel;
  logic               last_in_line;
  logic               out_valid;
  logic               out_stall;
  logic [PIX_W-1:0]   dst_pixel;
  logic               last_of_run;
  logic               line_done;

  // resampler state mirrored for prediction
  logic [CFG_LEN_W-1:0] cfg_src_len;
  logic [CFG_LEN_W-1:0] cfg_dst_len;
  logic [STEP_W-1:0]    cfg_step;
  logic [PIX_W-1:0]     prev_px;
  int unsigned          src_idx;
  int unsigned          dst_idx;
  longint               pos;

  dst_beat_t   pending_dst_q[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;

  linear_line_resampler_top u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .src_pixel    (src_pixel),
    .last_in_line (last_in_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dst_pixel    (dst_pixel),
    .last_of_run  (last_of_run),
    .line_done    (line_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned clamp_line_len(input logic [CFG_LEN_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_LINE_DEF) return MAX_LINE_DEF;
    return raw;
  endfunction

  function automatic int unsigned pick_len_value(input int unsigned hi);
    int unsigned v;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 1;
        2: v = 4096;
        default: v = 8191;
      endcase
    end else begin
      v = $urandom_range(2, hi);
    end
    return v;
  endfunction

  // works out the destination pixels caused by one accepted request
  task automatic resample_pixel(input logic [PIX_W-1:0] px, input logic mark);
    logic [PIX_W-1:0] run_px [MAX_UP];
    int unsigned      sl;
    int unsigned      dl;
    int unsigned      n;
    longint           lim;
    longint           frac_mask;
    longint           acc;
    logic             fin;
    sl = clamp_line_len(cfg_src_len);
    dl = clamp_line_len(cfg_dst_len);
    lim = longint'(sl - 1) << FRAC;
    frac_mask = (longint'(1) << FRAC) - 1;
    fin = mark || (src_idx + 1 >= sl);
    n = 0;
    if (src_idx > 0) begin
      while (n < MAX_UP && dst_idx < dl && (pos >> FRAC) <= longint'(src_idx) - 1) begin
        acc = (longint'(prev_px) << FRAC)
              + (longint'(px) - longint'(prev_px)) * (pos & frac_mask)
              + (longint'(1) << (FRAC - 1));
        if (acc < 0) acc = 0;
        acc = acc >> FRAC;
        run_px[n] = (acc > 255) ? 8'd255 : acc[7:0];
        n++;
        dst_idx++;
        pos = pos + longint'(cfg_step);
        if (pos > lim) pos = lim;
      end
    end
    if (fin) begin
      while (n < MAX_UP && dst_idx < dl) begin
        run_px[n] = px;
        n++;
        dst_idx++;
      end
      src_idx = 0;
      dst_idx = 0;
      pos = 0;
    end else begin
      src_idx++;
    end
    prev_px = px;
    for (int i = 0; i < n; i++) begin
      pending_dst_q.push_back('{run_px[i], i == n - 1, fin && (i == n - 1)});
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic mark);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    src_pixel    <= px;
    last_in_line <= mark;
    do @(posedge clk); while (in_stall);
    resample_pixel(px, mark);
  endtask

  task automatic end_stream;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle;
    int waited;
    waited = 0;
    while (pending_dst_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_dst_q.size() != 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("missing %0d destination pixels", pending_dst_q.size());
      pending_dst_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SRC_LEN: cfg_src_len = val[CFG_LEN_W-1:0];
      REG_DST_LEN: cfg_dst_len = val[CFG_LEN_W-1:0];
      REG_STEP:    cfg_step    = val[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_line(input int unsigned sl, input int unsigned dl,
                              input int unsigned step_val);
    end_stream;
    wait_idle;
    cfg_write(REG_SRC_LEN, sl);
    cfg_write(REG_DST_LEN, dl);
    cfg_write(REG_STEP, step_val);
  endtask

  // reset values: unit step, run cap on the final pixel
  task automatic test_reset_config;
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd255, 1'b1);
    end_stream;
    wait_idle;
  endtask

  // half step, rounding half up, line ends on src_len without the flag
  task automatic test_upscale_half_step;
    program_line(4, 7, 32768);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    end_stream;
    wait_idle;
  endtask

  // pixels in between cause no result
  task automatic test_downscale_gaps;
    program_line(5, 2, 4 << 16);
    send_pixel(8'd17, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd99, 1'b0);
    send_pixel(8'd254, 1'b0);
    end_stream;
    wait_idle;
  endtask

  // lengths clamped both ways, position stuck at zero
  task automatic test_zero_step_clamped;
    program_line(0, 8191, 0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd128, 1'b0);
    end_stream;
    wait_idle;
  endtask

  // destination line used up early, final pixel gives nothing
  task automatic test_dst_exhausted;
    program_line(8191, 2, 1);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd250, 1'b0);
    send_pixel(8'd85, 1'b0);
    send_pixel(8'd170, 1'b0);
    send_pixel(8'd42, 1'b1);
    end_stream;
    wait_idle;
  endtask

  // largest step saturates at the end of the line
  task automatic test_step_saturation;
    program_line(6, 4, 24'hFFFFFF);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd77, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd170, 1'b0);
    send_pixel(8'd85, 1'b0);
    end_stream;
    wait_idle;
  endtask

  task automatic test_random_lines(input int send_pct, input int recv_pct, input int quota);
    int unsigned sl_raw;
    int unsigned dl_raw;
    int unsigned sl;
    int unsigned dl;
    int unsigned step_val;
    int unsigned line_len;
    int unsigned cur_sl;
    int          sent;
    logic        mark;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < quota) begin
      if (sent == 0 || $urandom_range(0, 1) == 1) begin
        sl_raw = pick_len_value(24);
        dl_raw = pick_len_value(40);
        sl = clamp_line_len(sl_raw[CFG_LEN_W-1:0]);
        dl = clamp_line_len(dl_raw[CFG_LEN_W-1:0]);
        case ($urandom_range(0, 11))
          0: step_val = 0;
          1: step_val = 1;
          2: step_val = $urandom & 32'hFFFFFF;
          3: step_val = 32'hFFFFFF;
          default: step_val = (((sl - 1) << FRAC) / (dl - 1)) & 32'hFFFFFF;
        endcase
        program_line(sl_raw, dl_raw, step_val);
      end
      cur_sl = clamp_line_len(cfg_src_len);
      line_len = (cur_sl > 48) ? $urandom_range(2, 48) : cur_sl;
      if ($urandom_range(0, 9) == 0) line_len = $urandom_range(1, line_len);
      for (int i = 1; i <= line_len; i++) begin
        mark = (i == line_len) && (line_len < cur_sl || $urandom_range(0, 1) == 1);
        send_pixel(PIX_W'($urandom_range(0, 255)), mark);
      end
      sent += line_len;
    end
    end_stream;
    wait_idle;
  endtask

  // receiver holds off while the sender keeps offering a long upscale line
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_line(24, 70, (23 << FRAC) / 69);
    hold_left = 400;
    for (int i = 0; i < 24; i++) begin
      send_pixel(PIX_W'($urandom_range(0, 255)), i == 23);
    end
    end_stream;
    wait_idle;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    dst_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dst_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixel=%0d last_of_run=%0b line_done=%0b",
                   dst_pixel, last_of_run, line_done);
      end else begin
        want = pending_dst_q.pop_front();
        if (dst_pixel !== want.pixel || last_of_run !== want.run_end ||
            line_done !== want.line_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp pixel=%0d last_of_run=%0b line_done=%0b, got pixel=%0d last_of_run=%0b line_done=%0b",
                     want.pixel, want.run_end, want.line_end,
                     dst_pixel, last_of_run, line_done);
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    src_pixel     = '0;
    last_in_line  = 1'b0;
    cfg_src_len   = SRC_LEN_RST;
    cfg_dst_len   = DST_LEN_RST;
    cfg_step      = STEP_W'(1 << FRAC);
    prev_px       = '0;
    src_idx       = 0;
    dst_idx       = 0;
    pos           = 0;
    mismatches    = 0;
    cycle_count   = 0;
    hold_left     = 0;
    send_idle_pct = 31;
    recv_idle_pct = 65;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_config;
    test_upscale_half_step;
    test_downscale_gaps;
    test_zero_step_clamped;
    test_dst_exhausted;
    test_step_saturation;
    test_random_lines(31, 65, 130);
    test_random_lines(65, 31, 130);
    test_random_lines(0, 0, 130);
    test_backpressure;

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
